### sv/smdd_pkg.sv
`default_nettype none
package smdd_pkg;

  localparam int unsigned DelayDepth = 8192;
  localparam int unsigned AddrBits   = $clog2(DelayDepth);
  localparam int unsigned SampleBits = 24;
  localparam int unsigned SineDepth  = 256;
  localparam int unsigned SineBits   = $clog2(SineDepth) + 1;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned PosBits    = AddrBits + FracBits;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // configuration register indexes
  localparam logic [1:0] RegMix    = 2'd0;
  localparam logic [1:0] RegBase   = 2'd1;
  localparam logic [1:0] RegWobble = 2'd2;
  localparam logic [1:0] RegStep   = 2'd3;

  typedef logic [15:0] sine_tab_t [SineDepth+1];

  // Taylor series of sin in Q2.30, odd terms up to x^13/13!
  function automatic logic [15:0] quarter_sine(longint unsigned k);
    longint unsigned x;
    longint unsigned t;
    longint          s;
    begin
      x = (k * HalfPiQ30) / SineDepth;
      t = x;
      s = longint'(x);
      t = (t * x) >> 30; t = (t * x) >> 30; t = t / 6;   s = s - longint'(t);
      t = (t * x) >> 30; t = (t * x) >> 30; t = t / 20;  s = s + longint'(t);
      t = (t * x) >> 30; t = (t * x) >> 30; t = t / 42;  s = s - longint'(t);
      t = (t * x) >> 30; t = (t * x) >> 30; t = t / 72;  s = s + longint'(t);
      t = (t * x) >> 30; t = (t * x) >> 30; t = t / 110; s = s - longint'(t);
      t = (t * x) >> 30; t = (t * x) >> 30; t = t / 156; s = s + longint'(t);
      if (s < 0) s = 0;
      s = (s + 16384) >>> 15;
      if (s > 32767) s = 32767;
      return 16'(s);
    end
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    begin
      for (int k = 0; k <= SineDepth; k++) begin
        tab[k] = quarter_sine(longint'(k));
      end
      return tab;
    end
  endfunction

  localparam sine_tab_t SineTable = build_sine();

endpackage
`default_nettype wire

### sv/smdd_ram.sv
`default_nettype none
module smdd_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### sv/stereo_modulated_delay_doubler.sv
// Stereo doubler: modulated fractional delay with dry/wet mix.
// Input stream (s_axis): one stereo word per item, left in the low 24 bits.
// Output stream (m_axis): one mixed stereo word per input word, same packing.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 mix, 1 base lag, 2 wobble swing, 3 LFO phase step); write only when idle.
// After reset the delay memories, 8192 entries each, are swept to zero, one
// entry per cycle, with s_axis_tready low; configuration writes are taken then.
// Each word runs through an 11-step sequencer around one shared 26x18
// multiplier: wobble, read position, two taps per channel read over the
// single memory read port, interpolation and mix per channel. A word is
// accepted in the idle state and its result registered in the last step, so
// no word is taken until the prior one is through. The result waits in the
// output register while m_axis_tready is low; one further word may be taken
// meanwhile, and it holds in its last step until the output register frees.
`default_nettype none
module stereo_modulated_delay_doubler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [23:0] left_in, [47:24] right_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,   // [23:0] left_out, [47:24] right_out
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned Aw = smdd_pkg::AddrBits;
  localparam int unsigned Sw = smdd_pkg::SampleBits;
  localparam int unsigned Pw = smdd_pkg::PosBits;
  localparam int unsigned Fw = smdd_pkg::FracBits;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StWob   = 4'd2;
  localparam logic [3:0] StPos   = 4'd3;
  localparam logic [3:0] StRd0   = 4'd4;
  localparam logic [3:0] StRd1   = 4'd5;
  localparam logic [3:0] StTapL  = 4'd6;
  localparam logic [3:0] StTapR  = 4'd7;
  localparam logic [3:0] StDryL  = 4'd8;
  localparam logic [3:0] StWetL  = 4'd9;
  localparam logic [3:0] StDryR  = 4'd10;
  localparam logic [3:0] StWetR  = 4'd11;
  localparam logic [3:0] StFin   = 4'd12;

  localparam logic signed [Sw-1:0] SatMax = {1'b0, {(Sw-1){1'b1}}};
  localparam logic signed [Sw-1:0] SatMin = {1'b1, {(Sw-1){1'b0}}};

  // configuration
  logic [15:0] mix_q;
  logic [20:0] base_q;
  logic [19:0] wob_amp_q;
  logic [31:0] step_q;

  // control
  logic [3:0]    state_q, state_d;
  logic [Aw-1:0] clr_q, clr_d;
  logic [Aw-1:0] wp_q, wp_d;
  logic [31:0]   phase_q, phase_d;
  logic          out_valid_q, out_valid_d;

  // datapath
  logic signed [Sw-1:0] dry_l_q, dry_l_d, dry_r_q, dry_r_d;
  logic signed [15:0]   sine_q, sine_d;
  logic signed [43:0]   prod_q, prod_d;
  logic signed [44:0]   acc_q, acc_d;
  logic [Pw-1:0]        pos_q, pos_d;
  logic signed [Sw-1:0] a_l_q, a_l_d, a_r_q, a_r_d, b_r_q, b_r_d;
  logic signed [Sw-1:0] tap_l_q, tap_l_d, tap_r_q, tap_r_d;
  logic signed [Sw-1:0] res_l_q, res_l_d;
  logic [47:0]          out_q, out_d;

  logic                 accept;
  logic                 mem_we;
  logic [Aw-1:0]        mem_waddr, mem_raddr;
  logic [Sw-1:0]        wdata_l, wdata_r;
  logic signed [Sw-1:0] rdata_l, rdata_r;

  logic signed [25:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [43:0]   mul_p;
  logic [16:0]          dry_share;

  logic [1:0]           quad;
  logic [30:0]          rfold;
  logic [15:0]          sine_ent;
  logic signed [43:0]   rnd_wob, rnd_tap;
  logic signed [22:0]   wob, pos_full;
  logic signed [Sw:0]   diff;
  logic signed [44:0]   mix_sum;
  logic signed [28:0]   mix_sh;

  function automatic logic signed [Sw-1:0] sat(input logic signed [28:0] v);
    begin
      if (v > 29'(SatMax)) begin
        return SatMax;
      end else if (v < 29'(SatMin)) begin
        return SatMin;
      end
      return v[Sw-1:0];
    end
  endfunction

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // memories: one write and one read per cycle each
  assign mem_we    = (state_q == StClear) || accept;
  assign mem_waddr = (state_q == StClear) ? clr_q : wp_q;
  assign wdata_l   = (state_q == StClear) ? '0 : s_axis_tdata[Sw-1:0];
  assign wdata_r   = (state_q == StClear) ? '0 : s_axis_tdata[2*Sw-1:Sw];
  assign mem_raddr = (state_q == StRd1) ? pos_q[Pw-1:Fw] + Aw'(1) : pos_q[Pw-1:Fw];

  smdd_ram #(.Width(Sw), .Depth(smdd_pkg::DelayDepth)) u_ram_l (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wdata_l),
    .raddr_i (mem_raddr),
    .rdata_o (rdata_l)
  );

  smdd_ram #(.Width(Sw), .Depth(smdd_pkg::DelayDepth)) u_ram_r (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wdata_r),
    .raddr_i (mem_raddr),
    .rdata_o (rdata_r)
  );

  // LFO: fold the phase into a quarter wave and look up the sine
  assign quad     = phase_q[31:30];
  assign rfold    = quad[0] ? (31'h4000_0000 - {1'b0, phase_q[29:0]})
                            : {1'b0, phase_q[29:0]};
  assign sine_ent = smdd_pkg::SineTable[rfold[30:30-smdd_pkg::SineBits+1]];

  // shared multiplier
  assign dry_share = 17'h1_0000 - {1'b0, mix_q};
  assign diff      = (state_q == StTapL) ? ({rdata_l[Sw-1], rdata_l} - {a_l_q[Sw-1], a_l_q})
                                         : ({b_r_q[Sw-1], b_r_q} - {a_r_q[Sw-1], a_r_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StWob: begin
        mul_a = {6'd0, wob_amp_q};
        mul_b = {{2{sine_q[15]}}, sine_q};
      end
      StTapL, StTapR: begin
        mul_a = {diff[Sw], diff};
        mul_b = {10'd0, pos_q[Fw-1:0]};
      end
      StDryL: begin
        mul_a = {{2{dry_l_q[Sw-1]}}, dry_l_q};
        mul_b = {1'b0, dry_share};
      end
      StWetL: begin
        mul_a = {{2{tap_l_q[Sw-1]}}, tap_l_q};
        mul_b = {2'd0, mix_q};
      end
      StDryR: begin
        mul_a = {{2{dry_r_q[Sw-1]}}, dry_r_q};
        mul_b = {1'b0, dry_share};
      end
      StWetR: begin
        mul_a = {{2{tap_r_q[Sw-1]}}, tap_r_q};
        mul_b = {2'd0, mix_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding of the registered product
  assign rnd_wob  = prod_q + 44'sd16384;
  assign wob      = rnd_wob[37:15];
  assign pos_full = {2'b00, wp_q, {Fw{1'b0}}} - {2'b00, base_q} - wob;
  assign rnd_tap  = prod_q + 44'sd128;
  assign mix_sum  = acc_q + {prod_q[43], prod_q};
  assign mix_sh   = mix_sum[44:16];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    wp_d        = wp_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    dry_l_d     = dry_l_q;
    dry_r_d     = dry_r_q;
    sine_d      = sine_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    a_l_d       = a_l_q;
    a_r_d       = a_r_q;
    b_r_d       = b_r_q;
    tap_l_d     = tap_l_q;
    tap_r_d     = tap_r_q;
    res_l_d     = res_l_q;
    out_d       = out_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StClear: begin
        clr_d = clr_q + Aw'(1);
        if (clr_q == {Aw{1'b1}}) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          dry_l_d = s_axis_tdata[Sw-1:0];
          dry_r_d = s_axis_tdata[2*Sw-1:Sw];
          sine_d  = quad[1] ? (16'd0 - sine_ent) : sine_ent;
          state_d = StWob;
        end
      end
      StWob: begin
        prod_d  = mul_p;
        state_d = StPos;
      end
      StPos: begin
        pos_d   = pos_full[Pw-1:0];
        state_d = StRd0;
      end
      StRd0: begin
        state_d = StRd1;
      end
      StRd1: begin
        a_l_d   = rdata_l;
        a_r_d   = rdata_r;
        state_d = StTapL;
      end
      StTapL: begin
        b_r_d   = rdata_r;
        prod_d  = mul_p;
        state_d = StTapR;
      end
      StTapR: begin
        tap_l_d = a_l_q + rnd_tap[Sw+Fw-1:Fw];
        prod_d  = mul_p;
        state_d = StDryL;
      end
      StDryL: begin
        tap_r_d = a_r_q + rnd_tap[Sw+Fw-1:Fw];
        prod_d  = mul_p;
        state_d = StWetL;
      end
      StWetL: begin
        acc_d   = {prod_q[43], prod_q} + 45'sd32768;
        prod_d  = mul_p;
        state_d = StDryR;
      end
      StDryR: begin
        res_l_d = sat(mix_sh);
        prod_d  = mul_p;
        state_d = StWetR;
      end
      StWetR: begin
        acc_d   = {prod_q[43], prod_q} + 45'sd32768;
        prod_d  = mul_p;
        state_d = StFin;
      end
      StFin: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_d       = {sat(mix_sh), res_l_q};
          out_valid_d = 1'b1;
          wp_d        = wp_q + Aw'(1);
          phase_d     = phase_q + step_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      wp_q        <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      mix_q       <= 16'd32768;
      base_q      <= '0;
      wob_amp_q   <= '0;
      step_q      <= 32'd22370;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wp_q        <= wp_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          smdd_pkg::RegMix:    mix_q     <= cfg_data_i[15:0];
          smdd_pkg::RegBase:   base_q    <= cfg_data_i[20:0];
          smdd_pkg::RegWobble: wob_amp_q <= cfg_data_i[19:0];
          smdd_pkg::RegStep:   step_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dry_l_q <= dry_l_d;
    dry_r_q <= dry_r_d;
    sine_q  <= sine_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    pos_q   <= pos_d;
    a_l_q   <= a_l_d;
    a_r_q   <= a_r_d;
    b_r_q   <= b_r_d;
    tap_l_q <= tap_l_d;
    tap_r_q <= tap_r_d;
    res_l_q <= res_l_d;
    out_q   <= out_d;
  end

endmodule
`default_nettype wire
